FILE: rtl/eccr_pkg.sv
// ----------------------------------------------------------------------------
// eccr_pkg
// Widths, item type and rounding helpers shared by the collision resolver.
// ----------------------------------------------------------------------------
package eccr_pkg;

  localparam int VALUE_WIDTH = 24;
  localparam int RAD_W       = 16;

  localparam int DIFF_W      = 19;
  localparam int NEAR_LIMIT  = 1 << (DIFF_W - 1);
  localparam int D2_W        = 2 * DIFF_W - 1;
  localparam int SQ_W        = D2_W + 1;
  localparam int ROOT_STEPS  = (D2_W + 1) / 2;
  localparam int DIST_W      = ROOT_STEPS;
  localparam int RSUM_W      = RAD_W + 1;
  localparam int OV_W        = DIST_W + 1;

  localparam int NORM_SH     = 16;
  localparam int Q_W         = NORM_SH + 1;
  localparam int N_W         = Q_W + 1;
  localparam int NUM_W       = DIFF_W - 1 + NORM_SH + 1;

  localparam int DV_W        = VALUE_WIDTH + 1;
  localparam int PP_W        = N_W + OV_W;
  localparam int DOTP_W      = DV_W + N_W;
  localparam int PUSH_SH     = 17;
  localparam int PD_SH       = 8;
  localparam int ADJ_SH      = 24;
  localparam int PD_W        = DOTP_W + 1 - PD_SH + 1;
  localparam int AXP_W       = PD_W + N_W;
  localparam int CALC_W      = AXP_W - ADJ_SH + 3;

  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] x1;
    logic signed [VALUE_WIDTH-1:0] y1;
    logic signed [VALUE_WIDTH-1:0] x2;
    logic signed [VALUE_WIDTH-1:0] y2;
    logic signed [VALUE_WIDTH-1:0] vx1;
    logic signed [VALUE_WIDTH-1:0] vy1;
    logic signed [VALUE_WIDTH-1:0] vx2;
    logic signed [VALUE_WIDTH-1:0] vy2;
    logic signed [DV_W-1:0]        dvx;
    logic signed [DV_W-1:0]        dvy;
    logic signed [DIFF_W-1:0]      dx;
    logic signed [DIFF_W-1:0]      dy;
    logic [RSUM_W-1:0]             rsum;
    logic                          near;
  } pair_t;

  function automatic logic signed [63:0] rnd_pow2(input logic signed [63:0] v,
                                                  input int unsigned s);
    logic [63:0] m;
    logic [63:0] q;
    m = v[63] ? 64'(-v) : 64'(v);
    q = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] sat_val(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[VALUE_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[VALUE_WIDTH-1:0];
    end
    return v[VALUE_WIDTH-1:0];
  endfunction

endpackage

FILE: rtl/elastic_circle_collision_resolve.sv
// ----------------------------------------------------------------------------
// elastic_circle_collision_resolve
// Equal-mass elastic collision response for one pair of circles per beat.
//
//   channel | direction | payload
//   --------+-----------+-------------------------------------------------
//   in_     | input     | positions, velocities, radii of both bodies
//   out_    | output    | pushed positions, exchanged velocities, collided
//
// One pair enters per cycle while in_ready is high; the compute pipeline
// is built from the 19-step root and 17-step division pipelines.
// A 4-deep queue sits between the front register and the compute pipeline.
// A stall on out_ready freezes the pipeline; the queue keeps in_ready high
// until it fills. Synchronous reset clears only valid and pointer state.
// ----------------------------------------------------------------------------
module elastic_circle_collision_resolve import eccr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_first_x,
  input  logic signed [VALUE_WIDTH-1:0] in_first_y,
  input  logic signed [VALUE_WIDTH-1:0] in_second_x,
  input  logic signed [VALUE_WIDTH-1:0] in_second_y,
  input  logic signed [VALUE_WIDTH-1:0] in_first_vx,
  input  logic signed [VALUE_WIDTH-1:0] in_first_vy,
  input  logic signed [VALUE_WIDTH-1:0] in_second_vx,
  input  logic signed [VALUE_WIDTH-1:0] in_second_vy,
  input  logic [RAD_W-1:0]              in_first_radius,
  input  logic [RAD_W-1:0]              in_second_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [VALUE_WIDTH-1:0]        out_new_first_x,
  output logic [VALUE_WIDTH-1:0]        out_new_first_y,
  output logic [VALUE_WIDTH-1:0]        out_new_second_x,
  output logic [VALUE_WIDTH-1:0]        out_new_second_y,
  output logic [VALUE_WIDTH-1:0]        out_new_first_vx,
  output logic [VALUE_WIDTH-1:0]        out_new_first_vy,
  output logic [VALUE_WIDTH-1:0]        out_new_second_vx,
  output logic [VALUE_WIDTH-1:0]        out_new_second_vy,
  output logic                          out_collided
);

  logic  f_valid;
  logic  f_ready;
  pair_t f_item;
  logic  q_valid;
  logic  q_ready;
  pair_t q_item;

  eccr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_first_x       (in_first_x),
    .in_first_y       (in_first_y),
    .in_second_x      (in_second_x),
    .in_second_y      (in_second_y),
    .in_first_vx      (in_first_vx),
    .in_first_vy      (in_first_vy),
    .in_second_vx     (in_second_vx),
    .in_second_vy     (in_second_vy),
    .in_first_radius  (in_first_radius),
    .in_second_radius (in_second_radius),
    .f_valid          (f_valid),
    .f_ready          (f_ready),
    .f_item           (f_item)
  );

  eccr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  eccr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_new_first_x   (out_new_first_x),
    .out_new_first_y   (out_new_first_y),
    .out_new_second_x  (out_new_second_x),
    .out_new_second_y  (out_new_second_y),
    .out_new_first_vx  (out_new_first_vx),
    .out_new_first_vy  (out_new_first_vy),
    .out_new_second_vx (out_new_second_vx),
    .out_new_second_vy (out_new_second_vy),
    .out_collided      (out_collided)
  );

endmodule

FILE: rtl/eccr_front.sv
// ----------------------------------------------------------------------------
// eccr_front
// Accepts a pair, forms differences and the near-range class, holds one beat.
// ----------------------------------------------------------------------------
module eccr_front import eccr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_first_x,
  input  logic signed [VALUE_WIDTH-1:0] in_first_y,
  input  logic signed [VALUE_WIDTH-1:0] in_second_x,
  input  logic signed [VALUE_WIDTH-1:0] in_second_y,
  input  logic signed [VALUE_WIDTH-1:0] in_first_vx,
  input  logic signed [VALUE_WIDTH-1:0] in_first_vy,
  input  logic signed [VALUE_WIDTH-1:0] in_second_vx,
  input  logic signed [VALUE_WIDTH-1:0] in_second_vy,
  input  logic [RAD_W-1:0]              in_first_radius,
  input  logic [RAD_W-1:0]              in_second_radius,
  output logic                          f_valid,
  input  logic                          f_ready,
  output pair_t                         f_item
);

  localparam logic signed [VALUE_WIDTH:0] NEAR_P = (VALUE_WIDTH + 1)'(NEAR_LIMIT);

  logic signed [VALUE_WIDTH:0] dx_w;
  logic signed [VALUE_WIDTH:0] dy_w;
  pair_t item_nxt;
  pair_t item_r;
  logic  valid_r;
  logic  valid_nxt;
  logic  accept;

  assign in_ready = !valid_r || f_ready;
  assign accept   = in_valid && in_ready;
  assign f_valid  = valid_r;
  assign f_item   = item_r;

  always_comb begin
    dx_w          = (VALUE_WIDTH + 1)'(in_second_x) - (VALUE_WIDTH + 1)'(in_first_x);
    dy_w          = (VALUE_WIDTH + 1)'(in_second_y) - (VALUE_WIDTH + 1)'(in_first_y);
    item_nxt.x1   = in_first_x;
    item_nxt.y1   = in_first_y;
    item_nxt.x2   = in_second_x;
    item_nxt.y2   = in_second_y;
    item_nxt.vx1  = in_first_vx;
    item_nxt.vy1  = in_first_vy;
    item_nxt.vx2  = in_second_vx;
    item_nxt.vy2  = in_second_vy;
    item_nxt.dvx  = DV_W'(in_first_vx) - DV_W'(in_second_vx);
    item_nxt.dvy  = DV_W'(in_first_vy) - DV_W'(in_second_vy);
    item_nxt.dx   = dx_w[DIFF_W-1:0];
    item_nxt.dy   = dy_w[DIFF_W-1:0];
    item_nxt.rsum = RSUM_W'(in_first_radius) + RSUM_W'(in_second_radius);
    item_nxt.near = (dx_w < NEAR_P) && (dx_w > -NEAR_P) &&
                    (dy_w < NEAR_P) && (dy_w > -NEAR_P);
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (f_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: rtl/eccr_queue.sv
// ----------------------------------------------------------------------------
// eccr_queue
// Short FIFO between the classify front and the compute back.
// ----------------------------------------------------------------------------
module eccr_queue import eccr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  pair_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output pair_t pop_item
);

  pair_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = count_r != QCNT_W'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/eccr_back.sv
// ----------------------------------------------------------------------------
// eccr_back
// Pipelined distance root, normal division, push and velocity exchange.
// ----------------------------------------------------------------------------
module eccr_back import eccr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  pair_t                         q_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [VALUE_WIDTH-1:0]        out_new_first_x,
  output logic [VALUE_WIDTH-1:0]        out_new_first_y,
  output logic [VALUE_WIDTH-1:0]        out_new_second_x,
  output logic [VALUE_WIDTH-1:0]        out_new_second_y,
  output logic [VALUE_WIDTH-1:0]        out_new_first_vx,
  output logic [VALUE_WIDTH-1:0]        out_new_first_vy,
  output logic [VALUE_WIDTH-1:0]        out_new_second_vx,
  output logic [VALUE_WIDTH-1:0]        out_new_second_vy,
  output logic                          out_collided
);

  localparam int I_PREP = ROOT_STEPS + 1;
  localparam int NSTG   = ROOT_STEPS + Q_W + 5;

  typedef struct packed {
    logic signed [OV_W-1:0] ov;
    logic [DIST_W-1:0]      den;
    logic                   hit;
    logic                   nz;
  } ctl_t;

  logic  en;
  logic  v_r  [NSTG];
  pair_t it_r [NSTG];

  logic [SQ_W-1:0] sq_n_r   [ROOT_STEPS+1];
  logic [SQ_W-1:0] sq_res_r [ROOT_STEPS+1];
  logic [SQ_W-1:0] sq_n_nxt   [ROOT_STEPS];
  logic [SQ_W-1:0] sq_res_nxt [ROOT_STEPS];
  logic signed [2*DIFF_W-1:0] sqx;
  logic signed [2*DIFF_W-1:0] sqy;

  ctl_t             dv_ctl_r [Q_W+1];
  logic [NUM_W-1:0] rem_x_r  [Q_W+1];
  logic [NUM_W-1:0] rem_y_r  [Q_W+1];
  logic [Q_W-1:0]   q_x_r    [Q_W+1];
  logic [Q_W-1:0]   q_y_r    [Q_W+1];
  logic [NUM_W-1:0] rem_x_nxt [Q_W];
  logic [NUM_W-1:0] rem_y_nxt [Q_W];
  logic [Q_W-1:0]   q_x_nxt   [Q_W];
  logic [Q_W-1:0]   q_y_nxt   [Q_W];

  ctl_t              pr_ctl;
  logic [DIST_W-1:0] root_d;
  logic [DIFF_W-1:0] mag_x;
  logic [DIFF_W-1:0] mag_y;

  logic signed [N_W-1:0] qn_x;
  logic signed [N_W-1:0] qn_y;
  logic signed [N_W-1:0] nx_w;
  logic signed [N_W-1:0] ny_w;

  ctl_t                    m1_ctl_r;
  logic signed [N_W-1:0]   m1_nx_r;
  logic signed [N_W-1:0]   m1_ny_r;
  logic signed [PP_W-1:0]  m1_px_r;
  logic signed [PP_W-1:0]  m1_py_r;
  logic signed [DOTP_W-1:0] m1_dotx_r;
  logic signed [DOTP_W-1:0] m1_doty_r;

  ctl_t                    m2_ctl_r;
  logic signed [N_W-1:0]   m2_nx_r;
  logic signed [N_W-1:0]   m2_ny_r;
  logic signed [CALC_W-1:0] m2_px_r;
  logic signed [CALC_W-1:0] m2_py_r;
  logic signed [PD_W-1:0]  m2_pd_r;

  ctl_t                    m3_ctl_r;
  logic signed [CALC_W-1:0] m3_px_r;
  logic signed [CALC_W-1:0] m3_py_r;
  logic signed [AXP_W-1:0] m3_axp_r;
  logic signed [AXP_W-1:0] m3_ayp_r;

  logic signed [CALC_W-1:0] ax_w;
  logic signed [CALC_W-1:0] ay_w;
  logic                     apply;
  pair_t                    lt;

  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] nfx_r, nfy_r, nsx_r, nsy_r;
  logic [VALUE_WIDTH-1:0] nfvx_r, nfvy_r, nsvx_r, nsvy_r;
  logic                   col_r;

  assign en      = !out_valid_r || out_ready;
  assign q_ready = en;

  // stage control and payload chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) begin
        v_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_valid;
      for (int i = 1; i < NSTG; i++) begin
        v_r[i] <= v_r[i-1];
      end
      out_valid_r <= v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= q_item;
      for (int i = 1; i < NSTG; i++) begin
        it_r[i] <= it_r[i-1];
      end
    end
  end

  // squared distance and root iterations
  always_comb begin
    sqx = q_item.dx * q_item.dx;
    sqy = q_item.dy * q_item.dy;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      if (sq_n_r[k] >= sq_res_r[k] + (SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k)))) begin
        sq_n_nxt[k]   = sq_n_r[k] - (sq_res_r[k] + (SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k))));
        sq_res_nxt[k] = (sq_res_r[k] >> 1) + (SQ_W'(1) << (2 * (ROOT_STEPS - 1 - k)));
      end else begin
        sq_n_nxt[k]   = sq_n_r[k];
        sq_res_nxt[k] = sq_res_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_n_r[0]   <= $unsigned(sqx) + $unsigned(sqy);
      sq_res_r[0] <= '0;
      for (int k = 0; k < ROOT_STEPS; k++) begin
        sq_n_r[k+1]   <= sq_n_nxt[k];
        sq_res_r[k+1] <= sq_res_nxt[k];
      end
    end
  end

  // overlap, class and divider setup
  always_comb begin
    root_d     = sq_res_r[ROOT_STEPS][DIST_W-1:0];
    pr_ctl.ov  = OV_W'($signed({1'b0, it_r[ROOT_STEPS].rsum})) - $signed({1'b0, root_d});
    pr_ctl.hit = it_r[ROOT_STEPS].near && !pr_ctl.ov[OV_W-1] && (pr_ctl.ov != '0);
    pr_ctl.nz  = root_d != '0;
    pr_ctl.den = pr_ctl.nz ? root_d : DIST_W'(1);
    mag_x = it_r[ROOT_STEPS].dx[DIFF_W-1] ? DIFF_W'(-it_r[ROOT_STEPS].dx)
                                          : DIFF_W'(it_r[ROOT_STEPS].dx);
    mag_y = it_r[ROOT_STEPS].dy[DIFF_W-1] ? DIFF_W'(-it_r[ROOT_STEPS].dy)
                                          : DIFF_W'(it_r[ROOT_STEPS].dy);
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      rem_x_nxt[j] = rem_x_r[j];
      rem_y_nxt[j] = rem_y_r[j];
      q_x_nxt[j]   = q_x_r[j];
      q_y_nxt[j]   = q_y_r[j];
      if ((NUM_W + 1)'(rem_x_r[j]) >=
          ((NUM_W + 1)'(dv_ctl_r[j].den) << (Q_W - 1 - j))) begin
        rem_x_nxt[j] = rem_x_r[j] - (NUM_W'(dv_ctl_r[j].den) << (Q_W - 1 - j));
        q_x_nxt[j]   = q_x_r[j] | (Q_W'(1) << (Q_W - 1 - j));
      end
      if ((NUM_W + 1)'(rem_y_r[j]) >=
          ((NUM_W + 1)'(dv_ctl_r[j].den) << (Q_W - 1 - j))) begin
        rem_y_nxt[j] = rem_y_r[j] - (NUM_W'(dv_ctl_r[j].den) << (Q_W - 1 - j));
        q_y_nxt[j]   = q_y_r[j] | (Q_W'(1) << (Q_W - 1 - j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ctl_r[0] <= pr_ctl;
      rem_x_r[0]  <= (NUM_W'(mag_x) << NORM_SH) + NUM_W'(pr_ctl.den >> 1);
      rem_y_r[0]  <= (NUM_W'(mag_y) << NORM_SH) + NUM_W'(pr_ctl.den >> 1);
      q_x_r[0]    <= '0;
      q_y_r[0]    <= '0;
      for (int j = 0; j < Q_W; j++) begin
        dv_ctl_r[j+1] <= dv_ctl_r[j];
        rem_x_r[j+1]  <= rem_x_nxt[j];
        rem_y_r[j+1]  <= rem_y_nxt[j];
        q_x_r[j+1]    <= q_x_nxt[j];
        q_y_r[j+1]    <= q_y_nxt[j];
      end
    end
  end

  // signed normal, products, rounding
  always_comb begin
    qn_x = $signed({1'b0, q_x_r[Q_W]});
    qn_y = $signed({1'b0, q_y_r[Q_W]});
    nx_w = it_r[I_PREP+Q_W].dx[DIFF_W-1] ? -qn_x : qn_x;
    ny_w = it_r[I_PREP+Q_W].dy[DIFF_W-1] ? -qn_y : qn_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ctl_r  <= dv_ctl_r[Q_W];
      m1_nx_r   <= nx_w;
      m1_ny_r   <= ny_w;
      m1_px_r   <= nx_w * dv_ctl_r[Q_W].ov;
      m1_py_r   <= ny_w * dv_ctl_r[Q_W].ov;
      m1_dotx_r <= it_r[I_PREP+Q_W].dvx * nx_w;
      m1_doty_r <= it_r[I_PREP+Q_W].dvy * ny_w;

      m2_ctl_r  <= m1_ctl_r;
      m2_nx_r   <= m1_nx_r;
      m2_ny_r   <= m1_ny_r;
      m2_px_r   <= CALC_W'(rnd_pow2(64'(m1_px_r), PUSH_SH));
      m2_py_r   <= CALC_W'(rnd_pow2(64'(m1_py_r), PUSH_SH));
      m2_pd_r   <= PD_W'(rnd_pow2(64'(m1_dotx_r) + 64'(m1_doty_r), PD_SH));

      m3_ctl_r  <= m2_ctl_r;
      m3_px_r   <= m2_px_r;
      m3_py_r   <= m2_py_r;
      m3_axp_r  <= m2_pd_r * m2_nx_r;
      m3_ayp_r  <= m2_pd_r * m2_ny_r;
    end
  end

  // apply push and exchange, saturate
  always_comb begin
    lt    = it_r[NSTG-1];
    ax_w  = CALC_W'(rnd_pow2(64'(m3_axp_r), ADJ_SH));
    ay_w  = CALC_W'(rnd_pow2(64'(m3_ayp_r), ADJ_SH));
    apply = m3_ctl_r.hit && m3_ctl_r.nz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= m3_ctl_r.hit;
      if (apply) begin
        nfx_r  <= sat_val(64'(lt.x1) - 64'(m3_px_r));
        nfy_r  <= sat_val(64'(lt.y1) - 64'(m3_py_r));
        nsx_r  <= sat_val(64'(lt.x2) + 64'(m3_px_r));
        nsy_r  <= sat_val(64'(lt.y2) + 64'(m3_py_r));
        nfvx_r <= sat_val(64'(lt.vx1) - 64'(ax_w));
        nfvy_r <= sat_val(64'(lt.vy1) - 64'(ay_w));
        nsvx_r <= sat_val(64'(lt.vx2) + 64'(ax_w));
        nsvy_r <= sat_val(64'(lt.vy2) + 64'(ay_w));
      end else begin
        nfx_r  <= lt.x1;
        nfy_r  <= lt.y1;
        nsx_r  <= lt.x2;
        nsy_r  <= lt.y2;
        nfvx_r <= lt.vx1;
        nfvy_r <= lt.vy1;
        nsvx_r <= lt.vx2;
        nsvy_r <= lt.vy2;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_first_x   = nfx_r;
  assign out_new_first_y   = nfy_r;
  assign out_new_second_x  = nsx_r;
  assign out_new_second_y  = nsy_r;
  assign out_new_first_vx  = nfvx_r;
  assign out_new_first_vy  = nfvy_r;
  assign out_new_second_vx = nsvx_r;
  assign out_new_second_vy = nsvy_r;
  assign out_collided      = col_r;

endmodule

FILE: rtl/eccr_checker.sv
// ----------------------------------------------------------------------------
// eccr_checker
// Port-level checks on the collision resolver, bound to the top level.
// ----------------------------------------------------------------------------
module eccr_checker import eccr_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic signed [VALUE_WIDTH-1:0] in_first_x,
  input logic signed [VALUE_WIDTH-1:0] in_first_y,
  input logic signed [VALUE_WIDTH-1:0] in_second_x,
  input logic signed [VALUE_WIDTH-1:0] in_second_y,
  input logic signed [VALUE_WIDTH-1:0] in_first_vx,
  input logic signed [VALUE_WIDTH-1:0] in_first_vy,
  input logic signed [VALUE_WIDTH-1:0] in_second_vx,
  input logic signed [VALUE_WIDTH-1:0] in_second_vy,
  input logic [RAD_W-1:0]              in_first_radius,
  input logic [RAD_W-1:0]              in_second_radius,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [VALUE_WIDTH-1:0]        out_new_first_x,
  input logic [VALUE_WIDTH-1:0]        out_new_first_y,
  input logic [VALUE_WIDTH-1:0]        out_new_second_x,
  input logic [VALUE_WIDTH-1:0]        out_new_second_y,
  input logic [VALUE_WIDTH-1:0]        out_new_first_vx,
  input logic [VALUE_WIDTH-1:0]        out_new_first_vy,
  input logic [VALUE_WIDTH-1:0]        out_new_second_vx,
  input logic [VALUE_WIDTH-1:0]        out_new_second_vy,
  input logic                          out_collided
);

  localparam int CAP   = 1 + QDEPTH + ROOT_STEPS + Q_W + 5 + 1;
  localparam int PEND_W = $clog2(CAP + 1) + 1;

  logic [PEND_W-1:0] pend_r;
  logic              acc_in;
  logic              acc_out;

  assign acc_in  = in_valid && in_ready;
  assign acc_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (acc_in && !acc_out) begin
      pend_r <= pend_r + PEND_W'(1);
    end else if (acc_out && !acc_in) begin
      pend_r <= pend_r - PEND_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before its beat was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_new_first_x) && $stable(out_new_second_vy)
                               && $stable(out_collided))
    else $error("stalled result changed");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result shown with no pair in flight");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(CAP))
    else $error("more pairs in flight than the design can hold");

endmodule

bind elastic_circle_collision_resolve eccr_checker u_eccr_checker (.*);
